// ===== hdl/pcls_pkg.sv =====
// Shared types, register codes and the mask builder for the packed-code less-than scan.
// Used by pcls_cfg, packed_code_less_than_scan_top, pcls_scan_checker and testbench; depends on nothing else.
`default_nettype none
package pcls_pkg;

	// Default word width of the packed column words.
	localparam int WordBitsDefault = 64;

	// Register indexes of the configuration port.
	typedef enum logic [0:0] {
		CFG_CODE_BITS = 1'b0,
		CFG_PREDICATE = 1'b1
	} cfg_index_t;

	// Derived scan constants handed from the configuration block to the datapath.
	typedef struct packed {
		logic [63:0] mask;  // code bits of every whole field
		logic [63:0] rep;   // predicate repeated in every whole field
		logic        fits;  // at least one field fits in the word
		logic [5:0]  k;     // effective code width, never zero
	} cfg_t;

	// Builds the replicated masks from a code width and a predicate.
	// Each field is placed independently of the others.
	function automatic cfg_t build_cfg(input logic [5:0] code_bits, input logic [62:0] pred,
			input int word_bits);
		logic [5:0]  k;
		logic [6:0]  stride;
		logic [63:0] fmask;
		logic [63:0] p;
		int          base;
		cfg_t        c;
		k = (code_bits == 6'd0) ? 6'd1 : code_bits;
		stride = {1'b0, k} + 7'd1;
		fmask = (64'd1 << k) - 64'd1;
		p = {1'b0, pred} & fmask;
		c.mask = '0;
		c.rep = '0;
		for (int f = 0; f < 32; f++) begin
			base = f * int'(stride);
			if (base + int'(stride) <= word_bits) begin
				c.mask = c.mask | (fmask << base);
				c.rep = c.rep | (p << base);
			end
		end
		c.fits = (int'(stride) <= word_bits);
		c.k = k;
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/pcls_cfg.sv =====
// Configuration registers of the packed-code less-than scan and the masks derived from them.
// Depends on pcls_pkg for the register codes, the cfg_t struct and the mask builder.
`default_nettype none
module pcls_cfg #(
	parameter int WORD_BITS = pcls_pkg::WordBitsDefault
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [0:0]     cfg_index,
	input  wire logic [62:0]    cfg_data,
	output pcls_pkg::cfg_t      cfg
);

	logic [5:0]     code_bits_q;
	logic [62:0]    pred_q;
	pcls_pkg::cfg_t cfg_q;
	pcls_pkg::cfg_t cfg_new;
	logic [5:0]     code_bits_new;
	logic [62:0]    pred_new;

	// Decode the write and rebuild the masks from the values that will be stored.
	always_comb begin
		code_bits_new = code_bits_q;
		pred_new = pred_q;
		unique case (pcls_pkg::cfg_index_t'(cfg_index))
			pcls_pkg::CFG_CODE_BITS: code_bits_new = cfg_data[5:0];
			pcls_pkg::CFG_PREDICATE: pred_new = cfg_data;
			default: ;
		endcase
		cfg_new = pcls_pkg::build_cfg(code_bits_new, pred_new, WORD_BITS);
	end

	// Register values and derived masks update together on a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bits_q <= 6'd1;
			pred_q <= '0;
			cfg_q <= pcls_pkg::build_cfg(6'd1, 63'd0, WORD_BITS);
		end else if (cfg_we) begin
			code_bits_q <= code_bits_new;
			pred_q <= pred_new;
			cfg_q <= cfg_new;
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/packed_code_less_than_scan_top.sv =====
// A word closing a segment passes stages s1, s2 and s3, then the output register drives m_tvalid.
// Throughput: one word per cycle; each stage has its own valid bit, so words keep
// entering while a result waits, until every stage in front of the output is full.
// One result leaves per k+1 words, k being code_bits or one if it is zero. Reset is asynchronous and active low; it
// empties the pipeline and clears line index, segment vector, total and registers.
// Top level of the packed-code less-than scan; depends on pcls_pkg and pcls_cfg.
`default_nettype none
module packed_code_less_than_scan_top #(
	parameter int WORD_BITS = pcls_pkg::WordBitsDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,   // [63:0] packed_word
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [95:0]       m_tdata,   // [63:0] segment_bits, [95:64] match_count
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [62:0]  cfg_data
);

	localparam logic [63:0] WordMask = (WORD_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << WORD_BITS) - 64'd1);

	pcls_pkg::cfg_t cfg;

	pcls_cfg #(.WORD_BITS(WORD_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic        valid_s1, valid_s2, valid_s3, out_valid_q;
	logic [63:0] word_s1, r_s2, r_s3;
	logic [3:0]  cnt_s3 [8];
	logic [5:0]  line_q;
	logic [63:0] seg_q, out_seg_q;
	logic [31:0] total_q, out_cnt_q;
	logic        go3, adv3, adv2, adv1;

	// Stage handshakes: a stage loads when it is empty or its word moves on.
	assign go3 = valid_s3 && !(out_valid_q && !m_tready);
	assign adv3 = !valid_s3 || go3;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign s_tready = adv1;

	// Field compare: the add carries into the delimiter of every code below the predicate.
	logic [63:0] sum_w, r_w;
	always_comb begin
		sum_w = ((word_s1 & WordMask) ^ cfg.mask) + cfg.rep;
		r_w = cfg.fits ? (sum_w & WordMask & ~cfg.mask) : 64'd0;
	end

	// Per-byte population counts of the result.
	logic [3:0] cnt_w [8];
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			cnt_w[b] = 4'd0;
			for (int i = 0; i < 8; i++) begin
				cnt_w[b] = cnt_w[b] + {3'd0, r_s2[b*8+i]};
			end
		end
	end

	// Segment state update: total, shifted OR and line counting.
	logic [6:0]  cnt_tot;
	logic [32:0] total_sum;
	logic [31:0] total_new;
	logic [63:0] seg_new;
	always_comb begin
		cnt_tot = 7'd0;
		for (int b = 0; b < 8; b++) begin
			cnt_tot = cnt_tot + {3'd0, cnt_s3[b]};
		end
		total_sum = {1'b0, total_q} + {26'd0, cnt_tot};
		total_new = total_sum[32] ? {32{1'b1}} : total_sum[31:0];
		seg_new = seg_q | (r_s3 >> line_q);
	end

	// Pipeline valid bits, segment state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
			line_q <= '0;
			seg_q <= '0;
			total_q <= '0;
		end else begin
			if (adv1) valid_s1 <= s_tvalid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (m_tready && !(go3 && (line_q >= cfg.k))) out_valid_q <= 1'b0;
			if (go3) begin
				total_q <= total_new;
				if (line_q >= cfg.k) begin
					out_valid_q <= 1'b1;
					seg_q <= '0;
					line_q <= '0;
				end else begin
					seg_q <= seg_new;
					line_q <= line_q + 6'd1;
				end
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) word_s1 <= s_tdata;
		if (adv2 && valid_s1) r_s2 <= r_w;
		if (adv3 && valid_s2) begin
			r_s3 <= r_s2;
			cnt_s3 <= cnt_w;
		end
		if (go3 && (line_q >= cfg.k)) begin
			out_seg_q <= seg_new;
			out_cnt_q <= total_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_cnt_q, out_seg_q};

endmodule
`default_nettype wire

// ===== verif/pcls_scan_checker.sv =====
// Scoreboard for the packed-code less-than scan: it watches the word, result and register
// ports, predicts each segment result and compares it field by field.
// Depends on pcls_pkg for the register index codes and the default word width.
`default_nettype none
module pcls_scan_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,   // [63:0] packed_word
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [95:0] m_tdata,   // [63:0] segment_bits, [95:64] match_count
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [62:0] cfg_data,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WordBits = pcls_pkg::WordBitsDefault;

	typedef struct packed {
		logic [31:0] match_count;
		logic [63:0] segment_bits;
	} segment_result_t;

	// Register copies and scan state of the predictor.
	logic [5:0]      code_width;
	logic [62:0]     less_than;
	logic [5:0]      line_pos;
	logic [63:0]     seg_vector;
	logic [31:0]     running_total;
	segment_result_t segment_q[$];

	// Delimiter bits set for the codes of one word that fall below the predicate.
	function automatic logic [63:0] match_delims(input logic [63:0] w,
			input logic [5:0] width_reg, input logic [62:0] pred);
		logic [5:0]  k;
		int          stride;
		int          nfields;
		logic [63:0] fmask;
		logic [63:0] p;
		logic [63:0] mask;
		logic [63:0] rep;
		logic [63:0] wmask;
		k = (width_reg == 6'd0) ? 6'd1 : width_reg;
		stride = int'(k) + 1;
		nfields = WordBits / stride;
		fmask = (64'd1 << k) - 64'd1;
		p = {1'b0, pred} & fmask;
		wmask = (WordBits >= 64) ? '1 : ((64'd1 << WordBits) - 64'd1);
		mask = '0;
		rep = '0;
		for (int f = 0; f < nfields; f++) begin
			mask |= fmask << (f * stride);
			rep |= p << (f * stride);
		end
		if (nfields == 0)
			return '0;
		return ((((w & wmask) ^ mask) + rep) & wmask) & ~mask;
	endfunction

	// Register writes, word prediction and result comparison, all sampled at the clock edge.
	always @(posedge clk or negedge arst_n) begin
		logic [63:0]     delims;
		logic [32:0]     sum;
		logic [5:0]      k_eff;
		segment_result_t want;
		segment_result_t got;
		if (!arst_n) begin
			code_width = 6'd1;
			less_than = '0;
			line_pos = '0;
			seg_vector = '0;
			running_total = '0;
			segment_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// A result leaving now belongs to a word accepted earlier.
			if (m_tvalid && m_tready) begin
				got = segment_result_t'(m_tdata);
				if (segment_q.size() == 0) begin
					$display("%0t: unexpected result: segment_bits %h match_count %0d",
						$time, got.segment_bits, got.match_count);
					errors++;
				end else begin
					want = segment_q.pop_front();
					if (got.segment_bits !== want.segment_bits) begin
						$display("%0t: segment_bits expected %h actual %h",
							$time, want.segment_bits, got.segment_bits);
						errors++;
					end
					if (got.match_count !== want.match_count) begin
						$display("%0t: match_count expected %0d actual %0d",
							$time, want.match_count, got.match_count);
						errors++;
					end
				end
			end

			// Register writes leave the scan state alone.
			if (cfg_we) begin
				case (cfg_index)
					pcls_pkg::CFG_CODE_BITS: code_width = cfg_data[5:0];
					pcls_pkg::CFG_PREDICATE: less_than = cfg_data;
					default: ;
				endcase
			end

			// Count the matches of the word and close the segment on its last line.
			if (s_tvalid && s_tready) begin
				k_eff = (code_width == 6'd0) ? 6'd1 : code_width;
				delims = match_delims(s_tdata, code_width, less_than);
				sum = {1'b0, running_total} + 33'($countones(delims));
				running_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				seg_vector |= delims >> line_pos;
				if (line_pos >= k_eff) begin
					want.segment_bits = seg_vector;
					want.match_count = running_total;
					segment_q = {segment_q, want};
					seg_vector = '0;
					line_pos = '0;
				end else begin
					line_pos = line_pos + 6'd1;
				end
			end

			pending <= segment_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Top of the packed-code less-than scan testbench: clock, reset, register writes,
// word stimulus, output stalls and the verdict. Depends on pcls_pkg, the block
// packed_code_less_than_scan_top and the scoreboard pcls_scan_checker.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 2000;
	localparam int HoldCycles = 300;
	localparam int WordTarget = 450;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BEAT
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [63:0] packed_word
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // [63:0] segment_bits, [95:64] match_count
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [62:0] cfg_data;

	int errors;
	int pending;
	int words_sent;
	int burst_left;
	int idle_cycles = 0;
	bit hold_req;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	packed_code_less_than_scan_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pcls_scan_checker scoreboard (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	// Watchdog: ends the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// Output side: stall modes that change now and then, plus one long hold-off on request.
	initial begin
		rx_mode_t mode;
		int       left;
		m_tready <= 1'b0;
		mode = RX_OPEN;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HoldCycles - 1) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(40, 160);
				end
				left--;
				case (mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= (left % 3 != 0);
				endcase
			end
		end
	end

	// Writes both registers on back-to-back cycles; upper data bits of the width write are noise.
	task automatic set_config(input logic [5:0] width, input logic [62:0] pred);
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		cfg_we <= 1'b1;
		cfg_index <= pcls_pkg::CFG_CODE_BITS;
		cfg_data <= {noise[56:0], width};
		@(posedge clk);
		cfg_index <= pcls_pkg::CFG_PREDICATE;
		cfg_data <= pred;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one word until it is taken, then ends the burst with a random gap when due.
	task automatic send_word(input logic [63:0] w);
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
		end
	endtask

	// Stops offering and waits until every expected segment result has left the block.
	task automatic drain();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Builds a word of packed codes: mostly clean fields with codes near the predicate,
	// sometimes with stray high bits or set delimiters, sometimes pure noise.
	function automatic logic [63:0] make_word(input logic [5:0] width, input logic [62:0] pred);
		logic [5:0]  k;
		int          stride;
		int          nfields;
		int          pick;
		logic [63:0] fmask;
		logic [63:0] p;
		logic [63:0] code;
		logic [63:0] w;
		logic [63:0] area;
		k = (width == 6'd0) ? 6'd1 : width;
		stride = int'(k) + 1;
		nfields = 64 / stride;
		fmask = (64'd1 << k) - 64'd1;
		p = {1'b0, pred} & fmask;
		area = (64'd1 << (nfields * stride)) - 64'd1;
		pick = $urandom_range(0, 9);
		w = {$urandom, $urandom};
		if (pick < 2)
			return w;
		// Stray bits above the last field survive only on a few words.
		w = (pick == 8) ? (w & ~area) : '0;
		for (int f = 0; f < nfields; f++) begin
			case ($urandom_range(0, 5))
				0: code = p;
				1: code = p - 64'd1;
				2: code = p + 64'd1;
				3: code = '0;
				4: code = fmask;
				default: code = {$urandom, $urandom};
			endcase
			w |= (code & fmask) << (f * stride);
		end
		// Some words carry set delimiters, so carries cross into the next field.
		if (pick == 9)
			w |= {$urandom, $urandom} & area & ~(w | (fmask * 64'd0));
		return w;
	endfunction

	// Stimulus: reset, directed words, then random phases with fresh register settings.
	initial begin
		logic [5:0]  width;
		logic [62:0] pred;
		int          count;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= pcls_pkg::CFG_CODE_BITS;
		cfg_data <= '0;
		hold_req = 1'b0;
		words_sent = 0;
		burst_left = 8;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one-bit codes against a zero predicate.
		send_word('0);
		send_word('1);
		drain();

		// A code width of zero acts as one; the predicate keeps only its low bit.
		set_config(6'd0, '1);
		send_word('0);
		send_word({32{2'b01}});
		send_word({32{2'b10}});
		send_word('1);
		drain();

		// Codes below, equal to and with delimiters set against a predicate of four.
		set_config(6'd3, 63'd4);
		send_word({16{4'h3}});
		send_word({16{4'h4}});
		send_word({16{4'h8}});
		send_word('1);
		drain();

		// The width shrinks partway through a segment, which closes it on the next word.
		set_config(6'd6, '1);
		repeat (3) send_word({$urandom, $urandom});
		drain();
		set_config(6'd2, 63'd2);
		repeat (3) send_word({$urandom, $urandom});
		drain();

		// Random phases: widest codes first, then a long output stall at the narrowest width.
		for (int phase = 0; words_sent < WordTarget; phase++) begin
			case (phase)
				0: width = 6'd63;
				1: width = 6'd1;
				2: width = 6'd0;
				3: width = 6'd31;
				default: width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 3))
				0: pred = '0;
				1: pred = '1;
				default: pred = {$urandom, $urandom};
			endcase
			if (phase == 0)
				pred = '1;
			set_config(width, pred);
			count = (width >= 6'd24) ? int'(width) + 1 : $urandom_range(30, 60);
			if (phase == 1) begin
				count = 80;
				hold_req = 1'b1;
			end
			repeat (count) send_word(make_word(width, pred));
			drain();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
